// ===== rtl/shaq_pkg.sv =====
// Shared constants, types and helpers for the shifting-head array queue.
`timescale 1ns / 1ps
package shaq_pkg;

   localparam int CAPACITY = 8;
   localparam int DATA_W   = 8;
   localparam int COUNT_W  = 4;
   localparam int POS_W    = $clog2(CAPACITY + 1);
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   typedef logic [DATA_W-1:0]  data_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [ADDR_W-1:0]  addr_type;

   localparam logic     ACT_ENQUEUE = 1'b0;
   localparam logic     ACT_DEQUEUE = 1'b1;
   localparam data_type NONE_MARK   = data_type'(64);
   localparam pos_type  CAP_POS     = pos_type'(CAPACITY);
   localparam pos_type  FIRST_POS   = pos_type'(1);
   localparam pos_type  NO_POS      = pos_type'(0);

   // Positions are 1-based; the memory is addressed from 0.
   function automatic addr_type pos_to_addr(input pos_type pos);
      pos_type dec;
      dec = pos - FIRST_POS;
      return addr_type'(dec);
   endfunction

endpackage

// ===== rtl/shaq_req_if.sv =====
// Request channel of the shifting-head array queue.
`timescale 1ns / 1ps
interface shaq_req_if;
   logic                 valid;
   logic                 ready;
   logic                 action;
   shaq_pkg::data_type   data_in;

   modport source (output valid, output action, output data_in, input ready);
   modport sink   (input valid, input action, input data_in, output ready);
endinterface

// ===== rtl/shaq_rsp_if.sv =====
// Response channel of the shifting-head array queue.
`timescale 1ns / 1ps
interface shaq_rsp_if;
   logic                 valid;
   logic                 ready;
   shaq_pkg::data_type   data_out;
   logic                 rejected;
   logic                 is_empty;
   logic                 is_full;
   logic                 one_left;
   shaq_pkg::count_type  count;
   shaq_pkg::data_type   head_value;
   shaq_pkg::data_type   tail_value;

   modport source (output valid, output data_out, output rejected, output is_empty,
                   output is_full, output one_left, output count, output head_value,
                   output tail_value, input ready);
   modport sink   (input valid, input data_out, input rejected, input is_empty,
                   input is_full, input one_left, input count, input head_value,
                   input tail_value, output ready);
endinterface

// ===== rtl/shifting_head_array_queue.sv =====
// A result is registered from S_DONE once the response is free. A reject, a first enqueue or a
// dequeue with no memory read goes straight to S_DONE; an append passes S_APPEND, a dequeue that
// reads the new head byte S_HEADRD, and an enqueue at the last slot first S_SHIFT, which moves the
// live entries down one per cycle, then S_APPEND. One item is taken at a time, the next the cycle
// after a result is loaded; a response stall holds it. Reset clears the head and tail positions
// and the response; the slot memory is not cleared, since only live entries are ever read.
`timescale 1ns / 1ps
module shifting_head_array_queue (
   input  logic          clock,
   input  logic          reset,
   shaq_req_if.sink      req,
   shaq_rsp_if.source    rsp
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SHIFT  = 3'd1;
   localparam logic [2:0] S_APPEND = 3'd2;
   localparam logic [2:0] S_HEADRD = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   shaq_pkg::data_type slot_mem [shaq_pkg::CAPACITY];

   logic [2:0]          state_ff, state_in;
   shaq_pkg::pos_type   head_ff, head_in;
   shaq_pkg::pos_type   tail_ff, tail_in;
   shaq_pkg::data_type  head_val_ff, head_val_in;
   shaq_pkg::data_type  tail_val_ff, tail_val_in;
   shaq_pkg::data_type  data_ff, data_in;
   shaq_pkg::data_type  out_ff, out_in;
   logic                rej_ff, rej_in;
   shaq_pkg::pos_type   rd_pos_ff, rd_pos_in;
   shaq_pkg::pos_type   wr_pos_ff, wr_pos_in;
   logic                rd_more_ff, rd_more_in;
   shaq_pkg::data_type  rd_q_ff;

   logic                mem_we, mem_re;
   shaq_pkg::addr_type  mem_waddr, mem_raddr;
   shaq_pkg::data_type  mem_wdata;

   logic                rsp_valid_ff;
   shaq_pkg::data_type  rsp_data_ff, rsp_head_ff, rsp_tail_ff;
   logic                rsp_rej_ff, rsp_empty_ff, rsp_full_ff, rsp_one_ff;
   shaq_pkg::count_type rsp_count_ff;

   logic                q_empty, q_full, q_one, rsp_free, rsp_load;
   shaq_pkg::pos_type   q_count;

   assign q_empty  = (tail_ff == shaq_pkg::NO_POS);
   assign q_full   = (tail_ff == shaq_pkg::CAP_POS) && (head_ff == shaq_pkg::FIRST_POS);
   assign q_one    = (head_ff == tail_ff) && (head_ff != shaq_pkg::NO_POS);
   assign q_count  = q_empty ? shaq_pkg::NO_POS : (tail_ff - head_ff + shaq_pkg::FIRST_POS);
   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign rsp_load = (state_ff == S_DONE) && rsp_free;

   assign req.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      head_val_in = head_val_ff;
      tail_val_in = tail_val_ff;
      data_in     = data_ff;
      out_in      = out_ff;
      rej_in      = rej_ff;
      rd_pos_in   = rd_pos_ff;
      wr_pos_in   = wr_pos_ff;
      rd_more_in  = rd_more_ff;
      mem_we      = 1'b0;
      mem_waddr   = shaq_pkg::pos_to_addr(tail_ff);
      mem_wdata   = data_ff;
      mem_re      = 1'b0;
      mem_raddr   = shaq_pkg::pos_to_addr(rd_pos_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               data_in = req.data_in;
               out_in  = '0;
               rej_in  = 1'b0;
               if (req.action == shaq_pkg::ACT_ENQUEUE) begin
                  if (q_full) begin
                     rej_in   = 1'b1;
                     state_in = S_DONE;
                  end else if (q_empty) begin
                     mem_we      = 1'b1;
                     mem_waddr   = shaq_pkg::pos_to_addr(shaq_pkg::FIRST_POS);
                     mem_wdata   = req.data_in;
                     head_in     = shaq_pkg::FIRST_POS;
                     tail_in     = shaq_pkg::FIRST_POS;
                     head_val_in = req.data_in;
                     tail_val_in = req.data_in;
                     state_in    = S_DONE;
                  end else if (tail_ff == shaq_pkg::CAP_POS) begin
                     // Tail at the last slot with room below the head: move down first.
                     mem_re     = 1'b1;
                     mem_raddr  = shaq_pkg::pos_to_addr(head_ff);
                     rd_pos_in  = head_ff + shaq_pkg::FIRST_POS;
                     rd_more_in = (head_ff != shaq_pkg::CAP_POS);
                     wr_pos_in  = shaq_pkg::FIRST_POS;
                     state_in   = S_SHIFT;
                  end else begin
                     state_in = S_APPEND;
                  end
               end else begin
                  if (q_empty) begin
                     out_in   = shaq_pkg::NONE_MARK;
                     state_in = S_DONE;
                  end else if (q_one) begin
                     out_in   = head_val_ff;
                     head_in  = shaq_pkg::NO_POS;
                     tail_in  = shaq_pkg::NO_POS;
                     state_in = S_DONE;
                  end else begin
                     out_in    = head_val_ff;
                     head_in   = head_ff + shaq_pkg::FIRST_POS;
                     mem_re    = 1'b1;
                     mem_raddr = shaq_pkg::pos_to_addr(head_ff + shaq_pkg::FIRST_POS);
                     state_in  = S_HEADRD;
                  end
               end
            end
         end
         S_SHIFT: begin
            // The entry read last cycle lands at the next free low slot.
            mem_we    = 1'b1;
            mem_waddr = shaq_pkg::pos_to_addr(wr_pos_ff);
            mem_wdata = rd_q_ff;
            wr_pos_in = wr_pos_ff + shaq_pkg::FIRST_POS;
            if (rd_more_ff) begin
               mem_re     = 1'b1;
               mem_raddr  = shaq_pkg::pos_to_addr(rd_pos_ff);
               rd_more_in = (rd_pos_ff != shaq_pkg::CAP_POS);
               rd_pos_in  = rd_pos_ff + shaq_pkg::FIRST_POS;
            end else begin
               head_in  = shaq_pkg::FIRST_POS;
               tail_in  = wr_pos_ff;
               state_in = S_APPEND;
            end
         end
         S_APPEND: begin
            mem_we      = 1'b1;
            mem_waddr   = shaq_pkg::pos_to_addr(tail_ff + shaq_pkg::FIRST_POS);
            mem_wdata   = data_ff;
            tail_in     = tail_ff + shaq_pkg::FIRST_POS;
            tail_val_in = data_ff;
            state_in    = S_DONE;
         end
         S_HEADRD: begin
            head_val_in = rd_q_ff;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_q_ff <= slot_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         head_ff    <= shaq_pkg::NO_POS;
         tail_ff    <= shaq_pkg::NO_POS;
         rd_more_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         rd_more_ff <= rd_more_in;
      end
      head_val_ff <= head_val_in;
      tail_val_ff <= tail_val_in;
      data_ff     <= data_in;
      out_ff      <= out_in;
      rej_ff      <= rej_in;
      rd_pos_ff   <= rd_pos_in;
      wr_pos_ff   <= wr_pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff  <= out_ff;
         rsp_rej_ff   <= rej_ff;
         rsp_empty_ff <= q_empty;
         rsp_full_ff  <= q_full;
         rsp_one_ff   <= q_one;
         rsp_count_ff <= shaq_pkg::count_type'(q_count);
         rsp_head_ff  <= q_empty ? '0 : head_val_ff;
         rsp_tail_ff  <= q_empty ? '0 : tail_val_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.data_out   = rsp_data_ff;
   assign rsp.rejected   = rsp_rej_ff;
   assign rsp.is_empty   = rsp_empty_ff;
   assign rsp.is_full    = rsp_full_ff;
   assign rsp.one_left   = rsp_one_ff;
   assign rsp.count      = rsp_count_ff;
   assign rsp.head_value = rsp_head_ff;
   assign rsp.tail_value = rsp_tail_ff;

endmodule
